[sv/skcw_pkg.sv]
// ----------------------------------------------------------------------------
// skcw_pkg
// Shared types and codes for the sorted k-mer count writer.
// ----------------------------------------------------------------------------
package skcw_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_STAT   = 2'd2;
  localparam logic [1:0] OP_IDLE   = 2'd3;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_BCLOSE = 3'd1;
  localparam logic [2:0] KIND_FCLOSE = 3'd2;
  localparam logic [2:0] KIND_STAT   = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [10:0] SEL_UNIQUE   = 11'd0;
  localparam logic [10:0] SEL_DISTINCT = 11'd1;
  localparam logic [10:0] SEL_TOTAL    = 11'd2;
  localparam logic [10:0] SEL_OVERFLOW = 11'd3;
  localparam logic [10:0] SEL_MAX      = 11'd4;
  localparam logic [10:0] SEL_HIST0    = 11'd5;

  localparam logic CFG_MER_LENGTH  = 1'b0;
  localparam logic CFG_PREFIX_BITS = 1'b1;

  localparam int BIN_W = 48;

  // One result word before packing.
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] mer_suffix;
    logic        repeated;
    logic [63:0] extra_count;
    logic [31:0] bucket_index;
    logic [31:0] bucket_size;
    logic [31:0] empty_after;
    logic [63:0] stat_value;
    logic        last;
  } rec_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add64 = s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

[sv/skcw_hist.sv]
// ----------------------------------------------------------------------------
// skcw_hist
// Histogram memory: cleared after reset by a sweep, then incremented by a
// registered read-modify-write with forwarding, and read for statistics.
// ----------------------------------------------------------------------------
module skcw_hist #(
  parameter int HIST_BINS = 1024,
  parameter int AW = $clog2(HIST_BINS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 clear_busy,
  input  logic                 inc_en,
  input  logic [AW-1:0]        inc_addr,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [skcw_pkg::BIN_W-1:0] rd_data
);
  import skcw_pkg::*;

  logic [BIN_W-1:0] mem [HIST_BINS];
  logic [AW:0]      clr_cnt_r;
  logic             busy_r;
  // Stage of the increment: address and old value read from memory.
  logic             s1_v_r;
  logic [AW-1:0]    s1_a_r;
  logic [BIN_W-1:0] s1_q_r;
  logic             s1_fwd_r;
  logic [BIN_W-1:0] wb_d_r;
  logic [BIN_W-1:0] rq_r;
  logic             rfwd_r;
  logic [BIN_W-1:0] old_v, new_v;

  assign clear_busy = busy_r;
  assign old_v = s1_fwd_r ? wb_d_r : s1_q_r;
  assign new_v = (old_v == {BIN_W{1'b1}}) ? old_v : old_v + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
      s1_v_r    <= 1'b0;
    end else begin
      if (busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(HIST_BINS - 1)) busy_r <= 1'b0;
      end
      s1_v_r <= inc_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r   <= inc_addr;
    s1_q_r   <= mem[inc_addr];
    s1_fwd_r <= s1_v_r && (s1_a_r == inc_addr);
    if (s1_v_r) wb_d_r <= new_v;
    if (busy_r) mem[clr_cnt_r[AW-1:0]] <= '0;
    else if (s1_v_r) mem[s1_a_r] <= new_v;
    if (rd_en) begin
      rq_r   <= mem[rd_addr];
      rfwd_r <= s1_v_r && (s1_a_r == rd_addr);
    end
  end

  logic [BIN_W-1:0] nv_hold_r;
  always_ff @(posedge clk) if (rd_en) nv_hold_r <= new_v;
  assign rd_data = rfwd_r ? nv_hold_r : rq_r;

  a_no_inc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !inc_en) else $error("increment during clear");
  a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(clr_cnt_r) == (AW+1)'(HIST_BINS - 1))
    else $error("clear sweep length");
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> $past(s1_v_r)) else $error("forward without write");
endmodule

[sv/sorted_kmer_count_writer.sv]
// ----------------------------------------------------------------------------
// sorted_kmer_count_writer
// Merges an ascending k-mer stream into runs and emits data, bucket-close,
// statistic and error words.
// ----------------------------------------------------------------------------
// One input word is taken per clock. Each word yields up to two result words
// which are queued in a four-word output buffer; the input is taken while the
// buffer plus a pending statistic holds at most two words, so merges and
// statistics run at one word per cycle while the output port is ready, and a
// stream of words that each close a run together with a bucket is paced by
// the output port. Histogram bins live in a single memory with a registered
// read, updated by read-modify-write with forwarding. After reset the memory
// is cleared by a sweep over all HIST_BINS bins during which no input word is
// accepted. A statistic word waits in the statistic stage and enters the
// output buffer in the cycle after its input is accepted, from where it can
// leave; statistic values reflect every earlier word.
// tdata fields from the lowest bit up (input): op, mer_value, add_count,
// stat_select, zero pad to 14 bytes. tdata (output): kind, mer_suffix,
// repeated, extra_count, bucket_index, bucket_size, empty_after, stat_value,
// zero pad to 37 bytes; tlast is the last flag.
module sorted_kmer_count_writer #(
  parameter int HIST_BINS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [5:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // op, mer_value, add_count, stat_select
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [295:0] out_tdata,  // kind .. stat_value
  output logic         out_tlast
);
  import skcw_pkg::*;

  localparam int AW = $clog2(HIST_BINS);

  logic [5:0] mer_length_r, prefix_bits_r;
  logic [63:0] run_mer_r, run_count_r, total_r, distinct_r, unique_r, ovf_r, max_r;
  logic [32:0] bucket_r;
  logic [31:0] fill_r;
  logic        finished_r;

  logic [1:0]  op;
  logic [63:0] mer_in;
  logic [31:0] cnt_in;
  logic [10:0] sel;
  assign op     = in_tdata[1:0];
  assign mer_in = in_tdata[65:2];
  assign cnt_in = in_tdata[97:66];
  assign sel    = in_tdata[108:98];

  // Output buffer of four words.
  rec_t       q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  // Statistic stage waiting for histogram data.
  logic       st_v_r;
  logic       st_h_r;
  logic [63:0] st_val_r;
  logic       busy;

  // Each accepted word may push two records on top of what is buffered or
  // pending, so at most two words may be held when a word is taken.
  assign in_tready = !busy && (({1'b0, cnt_r} + {3'd0, st_v_r}) <= 4'd2);
  logic acc;
  assign acc = in_tvalid && in_tready;

  // Effective widths.
  logic [6:0] bits, pfx;
  always_comb begin
    logic [5:0] k;
    k = mer_length_r;
    if (k == 6'd0) k = 6'd1;
    if (k > 6'd32) k = 6'd32;
    bits = {k, 1'b0};
    pfx = (prefix_bits_r > 6'd32) ? 7'd32 : {1'b0, prefix_bits_r};
    if (pfx > bits) pfx = bits;
  end

  logic [63:0] mask, mer, smask, val;
  logic [64:0] nb;
  assign mask  = (bits == 7'd64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
  assign smask = ((bits - pfx) == 7'd64) ? {64{1'b1}} : ((64'd1 << (bits - pfx)) - 64'd1);
  assign mer   = mer_in & mask;
  assign val   = (pfx == 7'd0) ? 64'd0 : (mer >> (bits - pfx));
  assign nb    = 65'd1 << pfx;

  rec_t r0, r1;
  logic [1:0] npush;
  logic hinc;
  logic [AW-1:0] hinc_a;
  logic run_close;
  logic bcross;
  logic [63:0] c;
  assign c = run_count_r;

  always_comb begin
    r0 = '0; r1 = '0; npush = 2'd0; run_close = 1'b0; bcross = 1'b0;
    r0.mer_suffix  = run_mer_r & smask;
    r0.repeated    = (c > 64'd1);
    r0.extra_count = (c > 64'd1) ? c - 64'd2 : 64'd0;
    if (op == OP_ADD && !finished_r) begin
      if (mer < run_mer_r) begin
        r0 = '0; r0.kind = KIND_ERROR; npush = 2'd1;
      end else if (mer != run_mer_r) begin
        run_close = (c != 64'd0);
        if (run_close) npush = 2'd1;
        if ({31'd0, bucket_r} < val) begin
          bcross = 1'b1;
          r1.kind = KIND_BCLOSE;
          r1.bucket_index = bucket_r[31:0];
          r1.bucket_size = run_close && fill_r != '1 ? fill_r + 1'b1 : fill_r;
          r1.empty_after = 32'(val - {31'd0, bucket_r} - 64'd1);
          if (run_close) npush = 2'd2; else begin r0 = r1; npush = 2'd1; end
        end
      end
    end else if (op == OP_FINISH && !finished_r) begin
      run_close = (c != 64'd0);
      r1.kind = KIND_FCLOSE;
      r1.bucket_index = bucket_r[31:0];
      r1.bucket_size = run_close && fill_r != '1 ? fill_r + 1'b1 : fill_r;
      r1.empty_after = (nb > {32'd0, bucket_r}) ? 32'(nb - {32'd0, bucket_r} - 65'd1) : 32'd0;
      if (run_close) npush = 2'd2; else begin r0 = r1; npush = 2'd1; end
    end else if ((op == OP_ADD || op == OP_FINISH) && finished_r) begin
      r0 = '0; r0.kind = KIND_ERROR; npush = 2'd1;
    end
    if (npush == 2'd1) r0.last = 1'b1;
    if (npush == 2'd2) r1.last = 1'b1;
    hinc   = acc && run_close && (c < 64'(HIST_BINS));
    hinc_a = c[AW-1:0];
  end

  logic [10:0] hsel;
  logic [BIN_W-1:0] hq;
  assign hsel = sel - SEL_HIST0;
  skcw_hist #(.HIST_BINS(HIST_BINS), .AW(AW)) u_hist (
    .clk(clk), .rst_n(rst_n), .clear_busy(busy),
    .inc_en(hinc), .inc_addr(hinc_a),
    .rd_en(acc && op == OP_STAT), .rd_addr(AW'(hsel)), .rd_data(hq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mer_length_r <= 6'd22; prefix_bits_r <= 6'd12;
      run_mer_r <= '0; run_count_r <= '0; bucket_r <= '0; fill_r <= '0;
      total_r <= '0; distinct_r <= '0; unique_r <= '0; ovf_r <= '0; max_r <= '0;
      finished_r <= 1'b0; wp_r <= '0; rp_r <= '0; cnt_r <= '0; st_v_r <= 1'b0;
    end else begin
      logic [2:0] n;
      logic [1:0] w;
      n = cnt_r;
      w = wp_r;
      if (cfg_we) begin
        if (cfg_index == CFG_MER_LENGTH) mer_length_r <= cfg_data;
        else prefix_bits_r <= cfg_data;
      end
      if (out_tvalid && out_tready) begin rp_r <= rp_r + 1'b1; n = n - 1'b1; end
      st_v_r <= 1'b0;
      // The pending statistic goes ahead of the records of a word taken now.
      if (st_v_r) begin
        q_r[w] <= '{kind: KIND_STAT, stat_value: st_h_r ? {16'd0, hq} : st_val_r,
                    last: 1'b1, default: '0};
        w = w + 1'b1; n = n + 1'b1;
      end
      if (acc) begin
        if (op == OP_STAT) begin
          st_v_r <= 1'b1;
          st_h_r <= (sel >= SEL_HIST0) && ({21'd0, sel} - 32'd5 < 32'(HIST_BINS));
          case (sel)
            SEL_UNIQUE:   st_val_r <= unique_r;
            SEL_DISTINCT: st_val_r <= distinct_r;
            SEL_TOTAL:    st_val_r <= total_r;
            SEL_OVERFLOW: st_val_r <= ovf_r;
            SEL_MAX:      st_val_r <= max_r;
            default:      st_val_r <= 64'd0;
          endcase
        end else begin
          if (npush != 2'd0) q_r[w] <= r0;
          if (npush == 2'd2) q_r[w + 2'd1] <= r1;
          w = w + npush;
          n = n + {1'b0, npush};
          if (run_close) begin
            total_r <= sat_add64(total_r, c);
            distinct_r <= sat_add64(distinct_r, 64'd1);
            if (c >= 64'(HIST_BINS)) ovf_r <= sat_add64(ovf_r, 64'd1);
            if (max_r < c) max_r <= c;
            if (c == 64'd1) unique_r <= sat_add64(unique_r, 64'd1);
            // A bucket crossing restarts the fill instead.
            if (fill_r != '1 && !bcross) fill_r <= fill_r + 1'b1;
          end
          if (op == OP_ADD && !finished_r && mer > run_mer_r) begin
            run_mer_r <= mer;
            run_count_r <= {32'd0, cnt_in};
            if (bcross) begin
              bucket_r <= val[32:0];
              fill_r <= '0;
            end
          end else if (op == OP_ADD && !finished_r && mer == run_mer_r) begin
            run_count_r <= sat_add64(run_count_r, {32'd0, cnt_in});
          end else if (op == OP_FINISH && !finished_r) begin
            finished_r <= 1'b1;
            run_count_r <= '0;
          end
        end
      end
      wp_r <= w;
      cnt_r <= n;
    end
  end

  rec_t h;
  assign h = q_r[rp_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tlast = h.last;
  assign out_tdata = {4'd0, h.stat_value, h.empty_after, h.bucket_size, h.bucket_index,
                      h.extra_count, h.repeated, h.mer_suffix, h.kind};

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("output buffer overflow");
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("input taken during clear");
  a_stat_slot: assert property (@(posedge clk) disable iff (!rst_n)
    st_v_r |-> cnt_r <= 3'd3) else $error("no room for statistic");
endmodule
